[design/run_length_bit_vector_core_assert.svh]
// ----------------------------------------------------------------------------
// Run-length bit vector core assertion macros
// Shared concurrent assertion forms used by the interface checker.
// ----------------------------------------------------------------------------
`ifndef RUN_LENGTH_BIT_VECTOR_CORE_ASSERT_SVH
`define RUN_LENGTH_BIT_VECTOR_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define RLBV_ASSERT_NOW(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define RLBV_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

[design/rlbv_pkg.sv]
// ----------------------------------------------------------------------------
// Run-length bit vector package
// Sizes, table entry layout, cell commands and codes shared by the core.
// ----------------------------------------------------------------------------
package rlbv_pkg;

   localparam int MAX_RUNS    = 256;
   localparam int INDEX_BITS  = 20;
   localparam int KERNEL_BITS = 64;
   localparam int POS_W       = $clog2(MAX_RUNS);
   localparam int CNT_W       = POS_W + 1;
   localparam int REP_W       = INDEX_BITS + 1;
   localparam int K_W         = 7;
   localparam int BIT_W       = $clog2(KERNEL_BITS);

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_ALREADY = 2'd1;
   localparam logic [1:0] STATUS_FULL    = 2'd2;

   localparam logic OP_GET = 1'b0;
   localparam logic OP_SET = 1'b1;

   // A run is kept in units of groups: start group and group count.
   typedef struct packed {
      logic [INDEX_BITS-1:0] group;
      logic [REP_W-1:0]      repeats;
      logic [KERNEL_BITS-1:0] kernel;
   } entry_type;

   typedef enum logic [1:0] {
      CMD_HOLD,
      CMD_SHIFT,
      CMD_WRITE,
      CMD_MERGE
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type           op;
      logic [CNT_W-1:0]     pos;
      logic [1:0]           count;
      entry_type [2:0]      ents;
   } cmd_type;

   typedef struct packed {
      logic             found;
      logic [CNT_W-1:0] pos;
      entry_type        entry;
      logic             touch;
   } look_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV,
      ST_LOOK,
      ST_EVAL,
      ST_SHIFT,
      ST_WRITE,
      ST_CHK1,
      ST_MRG1,
      ST_CHK2,
      ST_MRG2,
      ST_DONE
   } state_type;

endpackage

[design/rlbv_divider.sv]
// ----------------------------------------------------------------------------
// Run-length bit vector index divider
// Restoring divider, one quotient bit per cycle, index over run width.
// ----------------------------------------------------------------------------
module rlbv_divider (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [rlbv_pkg::INDEX_BITS-1:0] dividend,
   input  logic [rlbv_pkg::K_W-1:0]        divisor,
   output logic                            done,
   output logic [rlbv_pkg::INDEX_BITS-1:0] quotient,
   output logic [rlbv_pkg::BIT_W-1:0]      remainder
);
   import rlbv_pkg::*;

   localparam int STEP_W = $clog2(INDEX_BITS);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [INDEX_BITS-1:0] quo_ff, quo_in;
   logic [K_W-1:0]        rem_ff, rem_in;
   logic [K_W-1:0]        div_ff, div_in;
   logic [K_W:0]          trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      trial   = {rem_ff, quo_ff[INDEX_BITS-1]};
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in = K_W'(trial - {1'b0, div_ff});
            quo_in = {quo_ff[INDEX_BITS-2:0], 1'b1};
         end else begin
            rem_in = trial[K_W-1:0];
            quo_in = {quo_ff[INDEX_BITS-2:0], 1'b0};
         end
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(INDEX_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff[BIT_W-1:0];

endmodule

[design/rlbv_cell.sv]
// ----------------------------------------------------------------------------
// Run-length bit vector table cell
// Holds one run; shifts up, shifts down on a merge, or loads a new run.
// ----------------------------------------------------------------------------
module rlbv_cell (
   input  logic                       clock,
   input  rlbv_pkg::cmd_type          cmd,
   input  logic [rlbv_pkg::CNT_W-1:0] idx,
   input  rlbv_pkg::entry_type        below,
   input  rlbv_pkg::entry_type        above,
   output rlbv_pkg::entry_type        entry
);
   import rlbv_pkg::*;

   entry_type        entry_ff, entry_in;
   logic [CNT_W-1:0] offset;

   always_comb begin
      entry_in = entry_ff;
      offset   = idx - cmd.pos;
      case (cmd.op)
         CMD_SHIFT: begin
            if (idx > cmd.pos) entry_in = below;
         end
         CMD_WRITE: begin
            if (idx >= cmd.pos && offset < CNT_W'(cmd.count)) begin
               entry_in = cmd.ents[offset[1:0]];
            end
         end
         CMD_MERGE: begin
            // The run at the merge point absorbs its upper neighbor.
            if (idx == cmd.pos) begin
               entry_in.repeats = entry_ff.repeats + above.repeats;
            end else if (idx > cmd.pos) begin
               entry_in = above;
            end
         end
         default: entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

[design/rlbv_chain.sv]
// ----------------------------------------------------------------------------
// Run-length bit vector cell chain
// Row of run cells with the lookup of the covering run and neighbor checks.
// ----------------------------------------------------------------------------
module rlbv_chain (
   input  logic                            clock,
   input  rlbv_pkg::cmd_type               cmd,
   input  logic [rlbv_pkg::CNT_W-1:0]      live,
   input  logic [rlbv_pkg::INDEX_BITS-1:0] quotient,
   input  logic [rlbv_pkg::CNT_W-1:0]      chk_pos,
   output rlbv_pkg::look_type              look
);
   import rlbv_pkg::*;

   entry_type           entries [MAX_RUNS];
   logic [MAX_RUNS:0]   le;
   logic [MAX_RUNS-1:0] touch;

   for (genvar i = 0; i < MAX_RUNS; i++) begin : g_cell
      rlbv_cell u_cell (
         .clock (clock),
         .cmd   (cmd),
         .idx   (CNT_W'(i)),
         .below (entries[(i == 0) ? 0 : i - 1]),
         .above (entries[(i == MAX_RUNS - 1) ? i : i + 1]),
         .entry (entries[i])
      );
   end

   always_comb begin
      le[MAX_RUNS] = 1'b0;
      for (int i = 0; i < MAX_RUNS; i++) begin
         le[i] = (CNT_W'(i) < live) && (entries[i].group <= quotient);
      end
      for (int i = 0; i < MAX_RUNS - 1; i++) begin
         touch[i] = (CNT_W'(i + 1) < live) &&
                    (entries[i].kernel == entries[i + 1].kernel) &&
                    (({1'b0, entries[i].group} + entries[i].repeats) ==
                     {1'b0, entries[i + 1].group});
      end
      touch[MAX_RUNS-1] = 1'b0;
   end

   // The table is sorted, so at most one cell sits at the end of the
   // covered prefix; its contents are collected by an OR reduction.
   always_comb begin
      look       = '0;
      look.found = le[0];
      for (int i = 0; i < MAX_RUNS; i++) begin
         if (le[i] && !le[i + 1]) begin
            look.pos   = look.pos | CNT_W'(i + 1);
            look.entry = look.entry | entries[i];
         end
         if (touch[i] && CNT_W'(i) == chk_pos) look.touch = 1'b1;
      end
   end

endmodule

[design/run_length_bit_vector_core.sv]
// ----------------------------------------------------------------------------
// Run-length bit vector core
// Compressed bit vector held as a sorted row of runs with get and set.
// ----------------------------------------------------------------------------
// Usage: an item on the req channel carries the operation in req_tuser and
// the bit index in req_tdata. Each item gives one transfer on the rsp
// channel with the old bit value, the run count, the peak run count and a
// status code. The csr channel writes the run width; a write empties the
// table and clears both counts, and is taken only while the core is idle
// and no result waits. A pending csr write holds off the req channel.
// An item passes from its transfer to the result register through the
// bit-serial divider (20 steps and its done flag) that splits the index
// into group and bit offset, a state that captures the lookup from the cell
// row and one that plans the update. A get, or a set that leaves the table
// unchanged, then loads its result. A set that changes the table first
// shifts cells as needed, writes the new runs, then runs two neighbor
// checks, each followed by a merge step. One item is in work at a time;
// none is taken before the last loads its result. A stalled receiver holds
// the result register, and a later item waits in its final state.
// Reset clears the run and peak counts and sets the run width to one.
module run_length_bit_vector_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [23:0]                   req_tdata,  // [19:0] bit_index
   input  logic [0:0]                    req_tuser,  // [0] operation
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // [0] bit_value, [9:1] run_count, [18:10] peak_run_count, [20:19] status
   output logic [23:0]                   rsp_tdata,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [rlbv_pkg::K_W-1:0]      csr_wdata
);
   import rlbv_pkg::*;

   state_type             state_ff, state_in;
   logic [K_W-1:0]        k_ff;
   logic [K_W-1:0]        k_eff;
   logic [CNT_W-1:0]      live_ff, peak_ff;
   logic                  op_ff;
   logic [INDEX_BITS-1:0] q_ff;
   logic [BIT_W-1:0]      r_ff;
   look_type              look_ff;
   look_type              look;
   logic                  bit_ff;
   logic [1:0]            status_ff;
   logic [CNT_W-1:0]      base_ff, at_ff, mid_ff;
   logic [1:0]            count_ff, shift_ff;
   entry_type [2:0]       ents_ff;
   logic [CNT_W:0]        newcount_ff;
   logic                  merge_ff;
   logic                  rsp_valid_ff;
   logic [23:0]           rsp_data_ff;

   logic                  div_start, div_done;
   logic [INDEX_BITS-1:0] div_q;
   logic [BIT_W-1:0]      div_r;
   cmd_type               cmd;
   logic [CNT_W-1:0]      chk_pos;

   // Planning signals for the update.
   logic                  ev_covered, ev_bit, ev_finish;
   logic [1:0]            ev_status;
   logic [KERNEL_BITS-1:0] ev_gmask;
   logic [INDEX_BITS-1:0] ev_grp;
   logic [REP_W-1:0]      ev_suf;
   logic [CNT_W-1:0]      ev_at, ev_mid;
   logic                  ev_removed;
   logic [1:0]            ev_count;
   entry_type [2:0]       ev_ents;
   logic [CNT_W:0]        ev_newcount;

   assign k_eff = (k_ff == '0 || k_ff > K_W'(KERNEL_BITS)) ? K_W'(1) : k_ff;

   rlbv_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (req_tdata[INDEX_BITS-1:0]),
      .divisor   (k_eff),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

   rlbv_chain u_chain (
      .clock    (clock),
      .cmd      (cmd),
      .live     (live_ff),
      .quotient (q_ff),
      .chk_pos  (chk_pos),
      .look     (look)
   );

   always_comb begin
      ev_covered = look_ff.found &&
                   ({1'b0, q_ff} < ({1'b0, look_ff.entry.group} + look_ff.entry.repeats));
      ev_bit     = ev_covered && look_ff.entry.kernel[r_ff];
      ev_gmask   = KERNEL_BITS'(1) << r_ff;
      ev_grp     = q_ff - look_ff.entry.group;
      ev_suf     = look_ff.entry.repeats - {1'b0, ev_grp} - REP_W'(1);
      ev_ents    = '0;
      ev_count   = 2'd0;
      if (!ev_covered) begin
         ev_at      = look_ff.pos;
         ev_removed = 1'b0;
         ev_mid     = look_ff.pos;
         ev_ents[0] = '{group: q_ff, repeats: REP_W'(1), kernel: ev_gmask};
         ev_count   = 2'd1;
      end else begin
         ev_at      = look_ff.pos - CNT_W'(1);
         ev_removed = 1'b1;
         ev_mid     = ev_at;
         if (ev_grp != '0) begin
            ev_ents[0] = '{group: look_ff.entry.group, repeats: {1'b0, ev_grp},
                           kernel: look_ff.entry.kernel};
            ev_count   = 2'd1;
            ev_mid     = ev_at + CNT_W'(1);
         end
         ev_ents[ev_count] = '{group: q_ff, repeats: REP_W'(1),
                               kernel: look_ff.entry.kernel | ev_gmask};
         ev_count = ev_count + 2'd1;
         if (ev_suf != '0) begin
            ev_ents[ev_count] = '{group: q_ff + INDEX_BITS'(1), repeats: ev_suf,
                                  kernel: look_ff.entry.kernel};
            ev_count = ev_count + 2'd1;
         end
      end
      ev_newcount = {1'b0, live_ff} - (CNT_W+1)'(ev_removed) + (CNT_W+1)'(ev_count);
      ev_status   = STATUS_OK;
      ev_finish   = 1'b1;
      if (op_ff == OP_SET) begin
         if (ev_bit) begin
            ev_status = STATUS_ALREADY;
         end else if (ev_newcount > (CNT_W+1)'(MAX_RUNS)) begin
            ev_status = STATUS_FULL;
         end else begin
            ev_finish = 1'b0;
         end
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_tvalid && req_tready) state_in = ST_DIV;
         ST_DIV:   if (div_done) state_in = ST_LOOK;
         ST_LOOK:  state_in = ST_EVAL;
         ST_EVAL:  state_in = ev_finish ? ST_DONE : ST_SHIFT;
         ST_SHIFT: if (shift_ff <= 2'd1) state_in = ST_WRITE;
         ST_WRITE: state_in = ST_CHK1;
         ST_CHK1:  state_in = ST_MRG1;
         ST_MRG1:  state_in = ST_CHK2;
         ST_CHK2:  state_in = ST_MRG2;
         ST_MRG2:  state_in = ST_DONE;
         ST_DONE:  if (!rsp_valid_ff || rsp_tready) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Outputs and cell commands.
   always_comb begin
      req_tready = (state_ff == ST_IDLE) && !csr_valid;
      csr_ready  = (state_ff == ST_IDLE) && !rsp_valid_ff;
      div_start  = req_tvalid && req_tready;
      chk_pos    = (state_ff == ST_CHK2) ? mid_ff - CNT_W'(1) : mid_ff;
      cmd        = '0;
      cmd.op     = CMD_HOLD;
      cmd.ents   = ents_ff;
      cmd.count  = count_ff;
      case (state_ff)
         ST_SHIFT: begin
            if (shift_ff != 2'd0) begin
               cmd.op  = CMD_SHIFT;
               cmd.pos = base_ff;
            end
         end
         ST_WRITE: begin
            cmd.op  = CMD_WRITE;
            cmd.pos = at_ff;
         end
         ST_MRG1: begin
            if (merge_ff) begin
               cmd.op  = CMD_MERGE;
               cmd.pos = mid_ff;
            end
         end
         ST_MRG2: begin
            if (merge_ff) begin
               cmd.op  = CMD_MERGE;
               cmd.pos = mid_ff - CNT_W'(1);
            end
         end
         default: cmd.op = CMD_HOLD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         k_ff         <= K_W'(1);
         live_ff      <= '0;
         peak_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            k_ff    <= csr_wdata;
            live_ff <= '0;
            peak_ff <= '0;
         end
         if (state_ff == ST_WRITE) begin
            live_ff <= newcount_ff[CNT_W-1:0];
            if (newcount_ff > {1'b0, peak_ff}) peak_ff <= newcount_ff[CNT_W-1:0];
         end
         if ((state_ff == ST_MRG1 || state_ff == ST_MRG2) && merge_ff) begin
            live_ff <= live_ff - CNT_W'(1);
         end
         if (state_ff == ST_DONE && (!rsp_valid_ff || rsp_tready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end

      if (req_tvalid && req_tready) op_ff <= req_tuser[0];
      if (state_ff == ST_DIV && div_done) begin
         q_ff <= div_q;
         r_ff <= div_r;
      end
      if (state_ff == ST_LOOK) look_ff <= look;
      if (state_ff == ST_EVAL) begin
         bit_ff      <= ev_bit;
         status_ff   <= ev_status;
         at_ff       <= ev_at;
         mid_ff      <= ev_mid;
         base_ff     <= ev_at + CNT_W'(ev_removed);
         count_ff    <= ev_count;
         shift_ff    <= ev_count - 2'(ev_removed);
         ents_ff     <= ev_ents;
         newcount_ff <= ev_newcount;
      end
      if (state_ff == ST_SHIFT && shift_ff != 2'd0) shift_ff <= shift_ff - 2'd1;
      if (state_ff == ST_CHK1) merge_ff <= look.touch;
      if (state_ff == ST_CHK2) merge_ff <= (mid_ff != '0) && look.touch;
      if (state_ff == ST_DONE && (!rsp_valid_ff || rsp_tready)) begin
         rsp_data_ff <= {3'b000, status_ff, peak_ff, live_ff, bit_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

[design/rlbv_checker.sv]
// ----------------------------------------------------------------------------
// Run-length bit vector interface checker
// Port-level properties of the core, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "run_length_bit_vector_core_assert.svh"

module rlbv_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);
   import rlbv_pkg::*;

   // A result waiting for the receiver must not change.
   `RLBV_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "rsp transfer changed while stalled")

   // Only one item is worked on at a time.
   `RLBV_ASSERT_NEXT(a_one_item, clock, reset, req_tvalid && req_tready, !req_tready, "req accepted while an item is in work")

   // The run count can never pass its own high-water mark.
   `RLBV_ASSERT_NOW(a_peak, clock, reset, rsp_tvalid, rsp_tdata[9:1] <= rsp_tdata[18:10], "run count above peak")

   // Status codes are limited to ok, already set and table full.
   `RLBV_ASSERT_NOW(a_status, clock, reset, rsp_tvalid, rsp_tdata[20:19] != 2'd3, "undefined status code")

endmodule

bind run_length_bit_vector_core rlbv_checker u_rlbv_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
